@@ src/pstr_pkg.sv @@
`timescale 1ns / 1ps

package pstr_pkg;

    // payload widths
    localparam int SEQ_W  = 32;
    localparam int ID_W   = 32;
    localparam int PC_W   = 32;
    localparam int TYPE_W = 8;
    localparam int CNT_W  = 7;

    // default ring depth
    localparam int DEPTH_DEF = 64;

    // request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic smp_wr;    // write a sample request into the ring
        logic rd_start;  // latch empty flag and count of a read request
        logic calc;      // work out start slot and start sequence
        logic load;      // load one reply into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being taken
        logic fin;       // next reply is the final one of the read
    } sts_t;

endpackage

@@ src/pstr_ctrl.sv @@
`timescale 1ns / 1ps

module pstr_ctrl
    import pstr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic req_type,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       acc;

    assign in_ready = (state_reg == ST_IDLE);
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        cmd.smp_wr   = acc && (req_type == REQ_SAMPLE);
        cmd.rd_start = acc && (req_type == REQ_READ);
        cmd.calc     = (state_reg == ST_CALC);
        cmd.load     = (state_reg == ST_LOAD) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.rd_start)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:  state_next = ST_FETCH;
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (cmd.load && sts.fin)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/pstr_dpath.sv @@
`timescale 1ns / 1ps

module pstr_dpath
    import pstr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic              user_mode,
    input  logic [PC_W-1:0]   user_pc,
    input  logic [PC_W-1:0]   kernel_pc,
    input  logic [ID_W-1:0]   thread_id,
    input  logic [TYPE_W-1:0] sample_type,
    input  logic [SEQ_W-1:0]  reader_seq,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              has_sample,
    output logic [ID_W-1:0]   out_id,
    output logic [PC_W-1:0]   out_pc,
    output logic [TYPE_W-1:0] out_type,
    output logic [CNT_W-1:0]  sample_count,
    output logic [SEQ_W-1:0]  current_seq,
    output logic              last
);

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // slot of sequence zero reached by wrapping 2^32 back, i.e. 2^32 mod depth
    localparam longint unsigned WRAP_REM = (64'd1 << SEQ_W) % DEPTH;
    localparam logic [SW-1:0] WRAP_SLOT = SW'(WRAP_REM);
    localparam logic [SW-1:0] LAST_SLOT = SW'(DEPTH - 1);

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PC_W-1:0]   pc;
        logic [TYPE_W-1:0] ty;
    } entry_t;

    entry_t            mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;

    logic [SEQ_W-1:0]  seq_reg;
    logic [SW-1:0]     wr_slot_reg;
    logic [SEQ_W-1:0]  seq_next;
    logic [SW-1:0]     wr_slot_next;

    logic              empty_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     rem_reg;
    logic [SEQ_W-1:0]  rd_seq_reg;
    logic [SW-1:0]     rd_slot_reg;
    logic [SW-1:0]     rd_slot_inc;
    logic [SW-1:0]     rd_addr;
    entry_t            rd_data_reg;
    logic              rd_vld_reg;

    logic [SEQ_W-1:0]  diff;
    logic [CW-1:0]     km1;
    logic              seq_wrap;
    logic [SW:0]       base;
    logic [SW:0]       sub;
    logic [SW:0]       start_sum;
    logic [SW-1:0]     start_slot;

    logic              out_valid_reg;
    logic              has_reg;
    entry_t            out_ent_reg;
    logic [CNT_W-1:0]  cnt_out_reg;
    logic [SEQ_W-1:0]  cur_reg;
    logic              last_reg;

    // write side
    assign seq_next     = seq_reg + SEQ_W'(1);
    assign wr_slot_next = (seq_next == '0) ? '0 :
                          ((wr_slot_reg == LAST_SLOT) ? '0 : wr_slot_reg + SW'(1));

    // read request: signed distance and clamped count
    assign diff = seq_reg - reader_seq;

    // start slot of the oldest reply, with care across the 2^32 wrap
    assign km1       = cnt_reg - CW'(1);
    assign seq_wrap  = (seq_reg < SEQ_W'(km1));
    assign base      = seq_wrap ? {1'b0, WRAP_SLOT} : {1'b0, wr_slot_reg};
    assign sub       = seq_wrap ? (SW+1)'(km1 - seq_reg[CW-1:0]) : (SW+1)'(km1);
    assign start_sum = base + ((SW+1)'(DEPTH) - sub);
    assign start_slot = (start_sum >= (SW+1)'(DEPTH)) ?
                        SW'(start_sum - (SW+1)'(DEPTH)) : start_sum[SW-1:0];

    // read walk
    assign rd_slot_inc = ((rd_seq_reg + SEQ_W'(1)) == '0) ? '0 :
                         ((rd_slot_reg == LAST_SLOT) ? '0 : rd_slot_reg + SW'(1));
    assign rd_addr     = cmd.load ? rd_slot_inc : rd_slot_reg;

    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.fin      = empty_reg || (rem_reg == CW'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.smp_wr)
        begin
            mem[wr_slot_next] <= '{id: thread_id,
                                   pc: (user_mode ? user_pc : kernel_pc),
                                   ty: sample_type};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            seq_reg     <= '0;
            wr_slot_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= valid_reg[rd_addr];
            if (cmd.smp_wr)
            begin
                valid_reg[wr_slot_next] <= 1'b1;
                seq_reg                 <= seq_next;
                wr_slot_reg             <= wr_slot_next;
            end
        end
    end

    // read sequencing, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.rd_start)
        begin
            empty_reg <= (diff == '0) || diff[SEQ_W-1];
            cnt_reg   <= (diff > SEQ_W'(DEPTH)) ? CW'(DEPTH) : diff[CW-1:0];
        end
        if (cmd.calc)
        begin
            rd_slot_reg <= start_slot;
            rd_seq_reg  <= seq_reg - SEQ_W'(km1);
            rem_reg     <= cnt_reg;
        end
        else if (cmd.load)
        begin
            rd_slot_reg <= rd_slot_inc;
            rd_seq_reg  <= rd_seq_reg + SEQ_W'(1);
            rem_reg     <= rem_reg - CW'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            has_reg     <= !empty_reg;
            out_ent_reg <= (empty_reg || !rd_vld_reg) ? '0 : rd_data_reg;
            cnt_out_reg <= empty_reg ? '0 : CNT_W'(cnt_reg);
            cur_reg     <= seq_reg;
            last_reg    <= sts.fin;
        end
    end

    assign out_valid    = out_valid_reg;
    assign has_sample   = has_reg;
    assign out_id       = out_ent_reg.id;
    assign out_pc       = out_ent_reg.pc;
    assign out_type     = out_ent_reg.ty;
    assign sample_count = cnt_out_reg;
    assign current_seq  = cur_reg;
    assign last         = last_reg;

endmodule

@@ src/pc_sample_trace_ring_unit.sv @@
`timescale 1ns / 1ps
// sample request: one per cycle between reads, gives no reply
// read request: start slot worked out, ring read primed, first reply loaded,
// then one reply per cycle while the consumer keeps out_ready high
// the next request is taken in the cycle after the final reply is loaded
// reset (rst_n low, asynchronous): sequence zero, all ring entries read as zero

module pc_sample_trace_ring_unit
    import pstr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF  // ring entries, 2 to 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  logic              user_mode,
    input  logic [PC_W-1:0]   user_pc,
    input  logic [PC_W-1:0]   kernel_pc,
    input  logic [ID_W-1:0]   thread_id,
    input  logic [TYPE_W-1:0] sample_type,
    input  logic [SEQ_W-1:0]  reader_seq,
    // reply channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic              has_sample,
    output logic [ID_W-1:0]   out_id,
    output logic [PC_W-1:0]   out_pc,
    output logic [TYPE_W-1:0] out_type,
    output logic [CNT_W-1:0]  sample_count,
    output logic [SEQ_W-1:0]  current_seq,
    output logic              last
);

    // command and status between the sequencer and the ring datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: idle, work out the start slot, prime the ring read,
    // then stream the replies oldest first
    pstr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd)
    );

    // ring datapath: sequence counter, write slot tracker, entry memory with
    // per-entry valid flags (unwritten entries read as zero), read walker and
    // the output register that decouples the reply channel
    pstr_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .user_mode    (user_mode),
        .user_pc      (user_pc),
        .kernel_pc    (kernel_pc),
        .thread_id    (thread_id),
        .sample_type  (sample_type),
        .reader_seq   (reader_seq),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .has_sample   (has_sample),
        .out_id       (out_id),
        .out_pc       (out_pc),
        .out_type     (out_type),
        .sample_count (sample_count),
        .current_seq  (current_seq),
        .last         (last)
    );

endmodule

@@ src/pstr_checker.sv @@
`timescale 1ns / 1ps

module pstr_checker
    import pstr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              has_sample,
    input logic [ID_W-1:0]   out_id,
    input logic [PC_W-1:0]   out_pc,
    input logic [TYPE_W-1:0] out_type,
    input logic [CNT_W-1:0]  sample_count,
    input logic [SEQ_W-1:0]  current_seq,
    input logic              last
);

    // stalled reply holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pc) && $stable(out_id)
                                    && $stable(out_type) && $stable(current_seq)
                                    && $stable(last))
        else $error("stalled reply changed");

    // empty reply is a single final reply with no count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_sample |-> last && (sample_count == '0) && (out_pc == '0))
        else $error("bad empty reply");

    // a carried sample comes with a non-zero count no larger than 64, the largest ring
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_sample |-> (sample_count != '0) && (sample_count <= CNT_W'(64)))
        else $error("bad sample count");

    // no new request taken while a non-final reply is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("request taken during a reply");

endmodule

bind pc_sample_trace_ring_unit pstr_checker u_pstr_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import pstr_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 400000;   // far above the slowest legal run
    localparam int HOLD_CYCLES  = 300;      // long consumer stall to back the ring up
    localparam int DRAIN_CYCLES = 20;       // settle time after the last reply, with plenty of slack
    localparam int IDLE_PCT     = 34;

    // one request as offered on the request channel
    typedef struct {
        logic              req_type;
        logic              user_mode;
        logic [PC_W-1:0]   user_pc;
        logic [PC_W-1:0]   kernel_pc;
        logic [ID_W-1:0]   thread_id;
        logic [TYPE_W-1:0] sample_type;
        logic [SEQ_W-1:0]  reader_seq;
    } trace_req_t;

    // one reply as seen on the reply channel
    typedef struct {
        logic              has_sample;
        logic [ID_W-1:0]   out_id;
        logic [PC_W-1:0]   out_pc;
        logic [TYPE_W-1:0] out_type;
        logic [CNT_W-1:0]  sample_count;
        logic [SEQ_W-1:0]  current_seq;
        logic              last;
    } trace_reply_t;

    // mirror of the trace ring plus the replies still owed by the block
    class trace_ring_scoreboard;
        logic [SEQ_W-1:0]  seq;
        logic [ID_W-1:0]   id_ring   [DEPTH];
        logic [PC_W-1:0]   pc_ring   [DEPTH];
        logic [TYPE_W-1:0] type_ring [DEPTH];
        trace_reply_t      awaited_replies [$];
        int                errors;

        function new();
            seq    = '0;
            errors = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                id_ring[i]   = '0;
                pc_ring[i]   = '0;
                type_ring[i] = '0;
            end
        endfunction

        // a sample request writes the ring, a read request queues its replies
        function void note_request(trace_req_t r);
            logic [SEQ_W-1:0] gap;
            logic [SEQ_W-1:0] first;
            int unsigned      n;
            int unsigned      slot;
            trace_reply_t     rep;
            if (r.req_type == REQ_SAMPLE)
            begin
                seq            = seq + 1;
                slot           = seq % DEPTH;
                id_ring[slot]   = r.thread_id;
                pc_ring[slot]   = r.user_mode ? r.user_pc : r.kernel_pc;
                type_ring[slot] = r.sample_type;
                return;
            end
            gap = seq - r.reader_seq;
            rep.current_seq = seq;
            if (gap == 0 || gap[SEQ_W-1])
            begin
                // reader is up to date or ahead: a single empty reply
                rep.has_sample   = 1'b0;
                rep.out_id       = '0;
                rep.out_pc       = '0;
                rep.out_type     = '0;
                rep.sample_count = '0;
                rep.last         = 1'b1;
                awaited_replies.push_back(rep);
                return;
            end
            // clamp to the newest DEPTH samples, oldest first
            n     = (gap > DEPTH) ? DEPTH : gap;
            first = seq - n + 1;
            for (int unsigned i = 0; i < n; i++)
            begin
                slot             = (first + i) % DEPTH;
                rep.has_sample   = 1'b1;
                rep.out_id       = id_ring[slot];
                rep.out_pc       = pc_ring[slot];
                rep.out_type     = type_ring[slot];
                rep.sample_count = n[CNT_W-1:0];
                rep.last         = (i + 1 == n);
                awaited_replies.push_back(rep);
            end
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            end
        endfunction

        function void check_reply(trace_reply_t got);
            trace_reply_t want;
            if (awaited_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply, expected none, actual id %h pc %h",
                         $time, got.out_id, got.out_pc);
                return;
            end
            want = awaited_replies.pop_front();
            compare_field("has_sample",   want.has_sample,   got.has_sample);
            compare_field("out_id",       want.out_id,       got.out_id);
            compare_field("out_pc",       want.out_pc,       got.out_pc);
            compare_field("out_type",     want.out_type,     got.out_type);
            compare_field("sample_count", want.sample_count, got.sample_count);
            compare_field("current_seq",  want.current_seq,  got.current_seq);
            compare_field("last",         want.last,         got.last);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              req_type;
    logic              user_mode;
    logic [PC_W-1:0]   user_pc;
    logic [PC_W-1:0]   kernel_pc;
    logic [ID_W-1:0]   thread_id;
    logic [TYPE_W-1:0] sample_type;
    logic [SEQ_W-1:0]  reader_seq;
    logic              out_valid;
    logic              out_ready;
    logic              has_sample;
    logic [ID_W-1:0]   out_id;
    logic [PC_W-1:0]   out_pc;
    logic [TYPE_W-1:0] out_type;
    logic [CNT_W-1:0]  sample_count;
    logic [SEQ_W-1:0]  current_seq;
    logic              last;

    trace_ring_scoreboard sb;
    trace_reply_t         seen_reply;
    logic [SEQ_W-1:0]     reader_pos;   // where a well-behaved reader has got to
    bit                   tx_idle_on;
    bit                   rx_idle_on;
    int                   hold_ticket;  // bumped to ask the consumer for a long stall
    int                   cycle_count;

    pc_sample_trace_ring_unit #(.DEPTH(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .user_mode    (user_mode),
        .user_pc      (user_pc),
        .kernel_pc    (kernel_pc),
        .thread_id    (thread_id),
        .sample_type  (sample_type),
        .reader_seq   (reader_seq),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .has_sample   (has_sample),
        .out_id       (out_id),
        .out_pc       (out_pc),
        .out_type     (out_type),
        .sample_count (sample_count),
        .current_seq  (current_seq),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit, counted in clock cycles
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // reply monitor: sampled at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_reply = '{has_sample, out_id, out_pc, out_type,
                           sample_count, current_seq, last};
            sb.check_reply(seen_reply);
        end
    end

    // consumer: random stalls, a stall-free mode, and a long hold on request
    initial
    begin
        int seen_ticket;
        int hold_left;
        seen_ticket = 0;
        hold_left   = 0;
        out_ready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (seen_ticket != hold_ticket)
            begin
                seen_ticket = hold_ticket;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else if (!rx_idle_on)
                out_ready = 1'b1;
            else
                out_ready = ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic trace_req_t make_sample(logic umode, logic [PC_W-1:0] upc,
                                               logic [PC_W-1:0] kpc, logic [ID_W-1:0] tid,
                                               logic [TYPE_W-1:0] sty);
        trace_req_t r;
        r.req_type    = REQ_SAMPLE;
        r.user_mode   = umode;
        r.user_pc     = upc;
        r.kernel_pc   = kpc;
        r.thread_id   = tid;
        r.sample_type = sty;
        r.reader_seq  = $urandom;   // ignored on a sample request
        return r;
    endfunction

    function automatic trace_req_t make_read(logic [SEQ_W-1:0] rseq);
        trace_req_t r;
        r             = make_sample($urandom_range(0, 1), $urandom, $urandom, $urandom,
                                    $urandom_range(0, 255));
        r.req_type    = REQ_READ;
        r.reader_seq  = rseq;
        return r;
    endfunction

    // most often a reader that follows the ring, plus lagging, ahead and wild readers
    function automatic trace_req_t pick_read();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            pick_read  = make_read(reader_pos);
            reader_pos = sb.seq;
        end
        else if (pick < 65)
            pick_read = make_read(sb.seq - $urandom_range(1, 70));
        else if (pick < 75)
            pick_read = make_read(sb.seq + $urandom_range(0, 2));
        else if (pick < 90)
            pick_read = make_read($urandom);
        else if (pick < 95)
            pick_read = make_read(sb.seq - 32'h7FFF_FFFF);
        else
            pick_read = make_read(sb.seq - 32'h8000_0000);
    endfunction

    // one request on the request channel; returns at the falling edge after acceptance
    task automatic send_request(trace_req_t r);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        req_type    = r.req_type;
        user_mode   = r.user_mode;
        user_pc     = r.user_pc;
        kernel_pc   = r.kernel_pc;
        thread_id   = r.thread_id;
        sample_type = r.sample_type;
        reader_seq  = r.reader_seq;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(r);
        @(negedge clk);
    endtask

    // about seven samples to three reads
    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 70)
                send_request(make_sample($urandom_range(0, 1), $urandom, $urandom,
                                         $urandom, $urandom_range(0, 255)));
            else
                send_request(pick_read());
        end
    endtask

    initial
    begin
        sb          = new();
        cycle_count = 0;
        hold_ticket = 0;
        reader_pos  = '0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = REQ_SAMPLE;
        user_mode   = 1'b0;
        user_pc     = '0;
        kernel_pc   = '0;
        thread_id   = '0;
        sample_type = '0;
        reader_seq  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty ring: nothing new, one never-written entry, negative gap, clamped read
        send_request(make_read(32'h0000_0000));
        send_request(make_read(32'hFFFF_FFFF));
        send_request(make_read(32'h8000_0000));
        send_request(make_read(32'h8000_0001));

        // pc selection and field extremes
        send_request(make_sample(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF));
        send_request(make_sample(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00));
        send_request(make_sample(1'b1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h1234_5678, 8'h5A));
        send_request(make_sample(1'b0, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h8765_4321, 8'hA5));

        // all since reset, exactly one new, up to date, reader one ahead
        send_request(make_read(32'h0000_0000));
        send_request(make_read(sb.seq - 1));
        send_request(make_read(sb.seq));
        send_request(make_read(sb.seq + 1));
        reader_pos = sb.seq;

        run_random(120);

        // stall-free stretch on both sides
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(80);

        // consumer stops for a long while, producer keeps pushing requests
        hold_ticket++;
        send_request(make_read(sb.seq - DEPTH));
        run_random(40);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random(70);

        in_valid = 1'b0;
        while (sb.awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
